>>> hdl/head_range_core_partitioner_macros.svh
// Assertion macros shared by the partitioner's checking code.
`ifndef HEAD_RANGE_CORE_PARTITIONER_MACROS_SVH
`define HEAD_RANGE_CORE_PARTITIONER_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define HRCP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define HRCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/hrcp_pkg.sv
// Shared constants, payload types and control structs of the head range partitioner.
package hrcp_pkg;

   localparam int MAX_BATCHES = 256;
   localparam int MAX_CORES   = 64;
   localparam int MAX_HEADS   = 256;

   localparam int BATCH_AW = $clog2(MAX_BATCHES);
   localparam int FILL_W   = $clog2(MAX_BATCHES + 1);
   localparam int CORE_W   = $clog2(MAX_CORES + 1);

   localparam int LEN_W   = 16;
   localparam int BLK_W   = 16;
   localparam int HEAD_W  = 9;
   localparam int CCNT_W  = 7;
   localparam int TOTAL_W = 32;
   localparam int CIDX_W  = 6;
   localparam int HIDX_W  = 16;
   localparam int HOFF_W  = HEAD_W - 1;
   localparam int TASK_W  = FILL_W + HEAD_W;

   localparam int DIV_W          = 32;
   localparam int DVSR_W         = 16;
   localparam int DIV_CNT_W      = $clog2(DIV_W + 1);
   localparam int DIV_STEPS_LEN  = LEN_W;
   localparam int DIV_STEPS_FULL = DIV_W;

   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;
   localparam int CSR_IDXW = CSR_AW - 2;

   typedef logic [CSR_IDXW-1:0] csr_idx_type;
   localparam csr_idx_type CSR_CORE_COUNT = csr_idx_type'(0);
   localparam csr_idx_type CSR_HEAD_COUNT = csr_idx_type'(1);
   localparam csr_idx_type CSR_BSIZE      = csr_idx_type'(2);

   localparam logic [CCNT_W-1:0] CORE_COUNT_RST = CCNT_W'(48);
   localparam logic [HEAD_W-1:0] HEAD_COUNT_RST = HEAD_W'(1);
   localparam logic [BLK_W-1:0]  BSIZE_RST      = BLK_W'(64);

   typedef struct packed {
      logic [LEN_W-1:0] seq_len;
      logic             last_batch;
   } req_type;

   typedef struct packed {
      logic [CIDX_W-1:0] core_index;
      logic [HIDX_W-1:0] first_head;
      logic [HIDX_W-1:0] last_head;
      logic              final_core;
      logic              overflow;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic store;
      logic emit_ovf;
      logic mul;
      logic div_tgt;
      logic rd;
      logic acc;
      logic emit;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic last_item;
      logic ovf_now;
      logic guard;
      logic hit;
      logic last_core;
   } status_type;

endpackage

>>> hdl/hrcp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hrcp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/hrcp_div.sv
// Restoring divider, one quotient bit per cycle, 16 or 32 steps.
module hrcp_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         half,
   input  logic [hrcp_pkg::DIV_W-1:0]   dividend,
   input  logic [hrcp_pkg::DVSR_W-1:0]  divisor,
   output logic                         done,
   output logic [hrcp_pkg::DIV_W-1:0]   quot,
   output logic [hrcp_pkg::DVSR_W-1:0]  rem
);
   import hrcp_pkg::*;

   logic [DVSR_W-1:0]    rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DVSR_W-1:0]    dvsr_ff, dvsr_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [DVSR_W:0]      shifted;
   logic [DVSR_W:0]      diff;
   logic                 fits;

   assign shifted = {rem_ff, quo_ff[DIV_W-1]};
   assign diff    = shifted - {1'b0, dvsr_ff};
   assign fits    = shifted >= {1'b0, dvsr_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvsr_in = dvsr_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvsr_in = divisor;
         cnt_in  = half ? DIV_CNT_W'(DIV_STEPS_LEN) : DIV_CNT_W'(DIV_STEPS_FULL);
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? diff[DVSR_W-1:0] : shifted[DVSR_W-1:0];
         quo_in  = {quo_ff[DIV_W-2:0], fits};
         cnt_in  = cnt_ff - DIV_CNT_W'(1);
         done_in = (cnt_ff == DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvsr_ff <= dvsr_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;
   assign rem  = rem_ff;

endmodule

>>> hdl/hrcp_dpath.sv
// Datapath: block-count store, running totals, target divider and partition walk.
module hrcp_dpath (
   input  logic                        clock,
   input  logic                        reset,
   input  hrcp_pkg::cmd_type           cmd,
   output hrcp_pkg::status_type        status,
   input  hrcp_pkg::req_type           req_word,
   input  logic [hrcp_pkg::CCNT_W-1:0] core_count,
   input  logic [hrcp_pkg::HEAD_W-1:0] head_count,
   input  logic [hrcp_pkg::BLK_W-1:0]  bsize,
   output logic                        rsp_valid,
   output hrcp_pkg::rsp_type           rsp_word
);
   import hrcp_pkg::*;

   logic [DIV_W-1:0]   div_dividend, div_quot;
   logic [DVSR_W-1:0]  div_divisor, div_rem;
   logic               div_start, div_done;
   logic [BLK_W-1:0]   bs_eff, blocks, rd_data;
   logic [HEAD_W-1:0]  heads_eff;
   logic [CORE_W-1:0]  cores_eff, used, left;
   logic               fill_full, guard, hit, last_core, advance;
   logic [TOTAL_W-1:0] acc_sum;

   logic               last_ff, last_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               ovf_ff, ovf_in;
   logic [HEAD_W-1:0]  heads_ff, heads_in;
   logic [CORE_W-1:0]  cores_ff, cores_in;
   logic [TASK_W-1:0]  tasks_ff, tasks_in;
   logic [TOTAL_W-1:0] remaining_ff, remaining_in;
   logic [TOTAL_W-1:0] count_ff, count_in;
   logic [CORE_W-1:0]  core_ff, core_in;
   logic [TASK_W-1:0]  end_ff, end_in;
   logic [TASK_W-1:0]  start_ff, start_in;
   logic [FILL_W-1:0]  batch_ff, batch_in;
   logic [HOFF_W-1:0]  hoff_ff, hoff_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   assign bs_eff = (bsize == '0) ? BLK_W'(1) : bsize;

   always_comb begin
      heads_eff = head_count;
      if (head_count == '0) begin
         heads_eff = HEAD_W'(1);
      end else if (head_count > HEAD_W'(MAX_HEADS)) begin
         heads_eff = HEAD_W'(MAX_HEADS);
      end
      cores_eff = CORE_W'(core_count);
      if (core_count == '0) begin
         cores_eff = CORE_W'(1);
      end else if (CORE_W'(core_count) > CORE_W'(MAX_CORES)) begin
         cores_eff = CORE_W'(MAX_CORES);
      end
   end

   // Lengths divide in 16 steps from the top half; targets take all 32.
   assign div_start    = cmd.accept | cmd.div_tgt;
   assign div_dividend = cmd.accept ? {req_word.seq_len, {(DIV_W-LEN_W){1'b0}}}
                                    : remaining_ff;
   assign div_divisor  = cmd.accept ? bs_eff : DVSR_W'(left);

   hrcp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .half     (cmd.accept),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   // Round up: add one when the division left a remainder.
   assign blocks    = div_quot[BLK_W-1:0] + BLK_W'(div_rem != '0);
   assign fill_full = (fill_ff == FILL_W'(MAX_BATCHES));

   hrcp_ram #(
      .WIDTH (BLK_W),
      .DEPTH (MAX_BATCHES)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.store && !fill_full),
      .wr_addr (fill_ff[BATCH_AW-1:0]),
      .wr_data (blocks),
      .rd_en   (cmd.rd),
      .rd_addr (batch_ff[BATCH_AW-1:0]),
      .rd_data (rd_data)
   );

   assign used      = (TASK_W'(cores_ff) > tasks_ff) ? tasks_ff[CORE_W-1:0] : cores_ff;
   assign left      = used - core_ff;
   assign guard     = (tasks_ff - end_ff) > TASK_W'(left);
   assign acc_sum   = count_ff + TOTAL_W'(rd_data);
   assign hit       = acc_sum >= div_quot;
   assign last_core = (core_ff + CORE_W'(1)) == used;
   assign advance   = (cmd.acc && !hit) || cmd.emit;

   always_comb begin
      last_in      = last_ff;
      fill_in      = fill_ff;
      total_in     = total_ff;
      ovf_in       = ovf_ff;
      heads_in     = heads_ff;
      cores_in     = cores_ff;
      tasks_in     = tasks_ff;
      remaining_in = remaining_ff;
      count_in     = count_ff;
      core_in      = core_ff;
      end_in       = end_ff;
      start_in     = start_ff;
      batch_in     = batch_ff;
      hoff_in      = hoff_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      if (cmd.accept) begin
         last_in = req_word.last_batch;
      end
      if (cmd.store) begin
         if (fill_full) begin
            ovf_in = 1'b1;
         end else begin
            fill_in  = fill_ff + FILL_W'(1);
            total_in = total_ff + TOTAL_W'(blocks);
         end
      end
      if (cmd.mul) begin
         heads_in     = heads_eff;
         cores_in     = cores_eff;
         tasks_in     = TASK_W'(fill_ff) * TASK_W'(heads_eff);
         remaining_in = total_ff * TOTAL_W'(heads_eff);
         core_in      = '0;
         end_in       = '0;
         start_in     = '0;
         batch_in     = '0;
         hoff_in      = '0;
      end
      if (cmd.div_tgt) begin
         count_in = '0;
      end
      if (cmd.acc) begin
         count_in = acc_sum;
      end
      // Step to the next task, tracking its batch without a divide.
      if (advance) begin
         end_in = end_ff + TASK_W'(1);
         if (HEAD_W'(hoff_ff) == heads_ff - HEAD_W'(1)) begin
            hoff_in  = '0;
            batch_in = batch_ff + FILL_W'(1);
         end else begin
            hoff_in = hoff_ff + HOFF_W'(1);
         end
      end
      if (cmd.emit) begin
         rsp_valid_in      = 1'b1;
         rsp_in.core_index = core_ff[CIDX_W-1:0];
         rsp_in.first_head = start_ff[HIDX_W-1:0];
         rsp_in.last_head  = end_ff[HIDX_W-1:0];
         rsp_in.final_core = last_core;
         rsp_in.overflow   = 1'b0;
         start_in          = end_ff + TASK_W'(1);
         remaining_in      = remaining_ff - count_ff;
         core_in           = core_ff + CORE_W'(1);
      end
      if (cmd.emit_ovf) begin
         rsp_valid_in      = 1'b1;
         rsp_in.core_index = '0;
         rsp_in.first_head = '0;
         rsp_in.last_head  = '0;
         rsp_in.final_core = 1'b1;
         rsp_in.overflow   = 1'b1;
      end
      if (cmd.clear) begin
         fill_in  = '0;
         total_in = '0;
         ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         total_ff     <= total_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff      <= last_in;
      heads_ff     <= heads_in;
      cores_ff     <= cores_in;
      tasks_ff     <= tasks_in;
      remaining_ff <= remaining_in;
      count_ff     <= count_in;
      core_ff      <= core_in;
      end_ff       <= end_in;
      start_ff     <= start_in;
      batch_ff     <= batch_in;
      hoff_ff      <= hoff_in;
      rsp_ff       <= rsp_in;
   end

   assign status.div_done  = div_done;
   assign status.last_item = last_ff;
   assign status.ovf_now   = ovf_ff | fill_full;
   assign status.guard     = guard;
   assign status.hit       = hit;
   assign status.last_core = last_core;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

>>> hdl/hrcp_ctrl.sv
// Controller state machine: sequences word intake and the per-core partition walk.
module hrcp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  hrcp_pkg::status_type status,
   output hrcp_pkg::cmd_type    cmd
);
   import hrcp_pkg::*;

   typedef enum logic [9:0] {
      IDLE     = 10'b00_0000_0001,
      DIV_LEN  = 10'b00_0000_0010,
      STORE    = 10'b00_0000_0100,
      EMIT_OVF = 10'b00_0000_1000,
      MUL      = 10'b00_0001_0000,
      TGT      = 10'b00_0010_0000,
      TGT_WAIT = 10'b00_0100_0000,
      CHK      = 10'b00_1000_0000,
      ACC      = 10'b01_0000_0000,
      EMIT     = 10'b10_0000_0000
   } state_type;

   state_type st_ff, st_in;

   always_comb begin
      st_in = st_ff;
      cmd   = '0;
      case (st_ff)
         IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               st_in      = DIV_LEN;
            end
         end
         DIV_LEN: begin
            if (status.div_done) begin
               st_in = STORE;
            end
         end
         STORE: begin
            cmd.store = 1'b1;
            if (!status.last_item) begin
               st_in = IDLE;
            end else if (status.ovf_now) begin
               st_in = EMIT_OVF;
            end else begin
               st_in = MUL;
            end
         end
         EMIT_OVF: begin
            cmd.emit_ovf = 1'b1;
            cmd.clear    = 1'b1;
            st_in        = IDLE;
         end
         MUL: begin
            cmd.mul = 1'b1;
            st_in   = TGT;
         end
         TGT: begin
            cmd.div_tgt = 1'b1;
            st_in       = TGT_WAIT;
         end
         TGT_WAIT: begin
            if (status.div_done) begin
               st_in = CHK;
            end
         end
         CHK: begin
            // Fetch the block count of the current task while enough tasks remain.
            if (status.guard) begin
               cmd.rd = 1'b1;
               st_in  = ACC;
            end else begin
               st_in = EMIT;
            end
         end
         ACC: begin
            cmd.acc = 1'b1;
            st_in   = status.hit ? EMIT : CHK;
         end
         EMIT: begin
            cmd.emit = 1'b1;
            if (status.last_core) begin
               cmd.clear = 1'b1;
               st_in     = IDLE;
            end else begin
               st_in = TGT;
            end
         end
         default: begin
            st_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   assign busy = (st_ff != IDLE);

endmodule

>>> hdl/head_range_core_partitioner.sv
// Top level: register port, controller and datapath of the head range partitioner.
// Each length word is divided by the 16-step divider and stored before the next accept.
// The marked word then scales the totals; per core follow a 32-step target divide,
// a check and fetch per walked task, one more check when the walk stops on its guard, and an emit.
// One result per used core, or one overflow word, is strobed for a single cycle; none can stall.
// Synchronous active-high reset clears control state and restores register defaults;
// the block-count store is not cleared and needs no clearing pass.
`include "head_range_core_partitioner_macros.svh"

module head_range_core_partitioner (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  hrcp_pkg::req_type             req_word,
   output logic                          rsp_valid,
   output hrcp_pkg::rsp_type             rsp_word,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [hrcp_pkg::CSR_AW-1:0]   paddr,
   input  logic [hrcp_pkg::CSR_DW-1:0]   pwdata,
   output logic [hrcp_pkg::CSR_DW-1:0]   prdata,
   output logic                          pready
);
   import hrcp_pkg::*;

   logic [CCNT_W-1:0] core_count_ff, core_count_in;
   logic [HEAD_W-1:0] head_count_ff, head_count_in;
   logic [BLK_W-1:0]  bsize_ff, bsize_in;
   logic              csr_wr;
   csr_idx_type       csr_idx;
   cmd_type           cmd;
   status_type        status;
   logic              emit_any;
   logic              rsp_ovf;
   logic              rsp_lone;

   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite & pready;
   assign csr_idx = paddr[CSR_AW-1:2];

   always_comb begin
      core_count_in = core_count_ff;
      head_count_in = head_count_ff;
      bsize_in      = bsize_ff;
      if (csr_wr) begin
         case (csr_idx)
            CSR_CORE_COUNT: core_count_in = pwdata[CCNT_W-1:0];
            CSR_HEAD_COUNT: head_count_in = pwdata[HEAD_W-1:0];
            CSR_BSIZE:      bsize_in      = pwdata[BLK_W-1:0];
            default: begin
               // drop writes past the register list
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_CORE_COUNT: prdata = CSR_DW'(core_count_ff);
         CSR_HEAD_COUNT: prdata = CSR_DW'(head_count_ff);
         CSR_BSIZE:      prdata = CSR_DW'(bsize_ff);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         core_count_ff <= CORE_COUNT_RST;
         head_count_ff <= HEAD_COUNT_RST;
         bsize_ff      <= BSIZE_RST;
      end else begin
         core_count_ff <= core_count_in;
         head_count_ff <= head_count_in;
         bsize_ff      <= bsize_in;
      end
   end

   hrcp_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   hrcp_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_word   (req_word),
      .core_count (core_count_ff),
      .head_count (head_count_ff),
      .bsize      (bsize_ff),
      .rsp_valid  (rsp_valid),
      .rsp_word   (rsp_word)
   );

   assign emit_any = cmd.emit | cmd.emit_ovf;
   assign rsp_ovf  = rsp_valid & rsp_word.overflow;
   assign rsp_lone = rsp_word.final_core & (rsp_word.core_index == '0);

   `HRCP_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accept left block idle")
   `HRCP_ASSERT_NEXT(a_emit_strobe, clock, reset, emit_any, rsp_valid, "emit without strobe")
   `HRCP_ASSERT_NEXT(a_strobe_gap, clock, reset, rsp_valid, !rsp_valid, "results back to back")
   `HRCP_ASSERT_SAME(a_ovf_alone, clock, reset, rsp_ovf, rsp_lone, "overflow word not alone")

endmodule
